// File: rtl/core/ipv4hb_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hb_pkg
// types and fixed constants shared by the ipv4 header builder modules
// ----------------------------------------------------------------------------
package ipv4hb_pkg;

    localparam int unsigned HDR_WORDS = 5;

    localparam logic [7:0]  VER_IHL      = 8'h45;
    localparam logic [7:0]  TTL_VALUE    = 8'd64;
    localparam logic [7:0]  PROTO_UDP    = 8'h11;
    localparam logic [16:0] HDR_BYTES    = 17'd20;
    localparam logic [2:0]  HDR_LAST_POS = 3'd4;

    // input transaction
    typedef struct packed {
        logic [15:0] payload_length;
        logic [15:0] datagram_id;
        logic [12:0] frag_offset;
        logic        more_frag;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [31:0] header_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_error;
    } t_out_item;

    // one built header, or an error marker
    typedef struct packed {
        logic                          err;
        logic [HDR_WORDS-1:0][31:0]    words;
    } t_hdr_entry;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        t_hdr_entry entry;
    } t_q_head;

endpackage

// File: rtl/core/ipv4hb_front.sv
// ----------------------------------------------------------------------------
// ipv4hb_front
// accepts transactions, checks length, builds header words and checksum
// ----------------------------------------------------------------------------
module ipv4hb_front
    import ipv4hb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_push,
    output t_hdr_entry o_push_entry,
    input  logic       i_q_full
);

    logic        r_valid;
    t_hdr_entry  r_entry;
    logic [19:0] r_sum;

    t_hdr_entry  n_entry;
    logic [19:0] n_sum;
    logic [16:0] total;
    logic        load;
    logic [16:0] fold1;
    logic [15:0] fold2;

    // header without checksum, and the raw 16-bit half sum
    always_comb begin
        total = {1'b0, i_in_item.payload_length} + HDR_BYTES;
        n_entry.err = total[16];
        n_entry.words[0] = {VER_IHL, 8'h00, total[15:0]};
        n_entry.words[1] = {i_in_item.datagram_id, 2'b00, i_in_item.more_frag,
                            i_in_item.frag_offset};
        n_entry.words[2] = {TTL_VALUE, PROTO_UDP, 16'h0000};
        n_entry.words[3] = i_in_item.source_address;
        n_entry.words[4] = i_in_item.destination_address;
        n_sum = {4'h0, VER_IHL, 8'h00} + {4'h0, total[15:0]}
              + {4'h0, n_entry.words[1][31:16]} + {4'h0, n_entry.words[1][15:0]}
              + {4'h0, TTL_VALUE, PROTO_UDP}
              + {4'h0, i_in_item.source_address[31:16]}
              + {4'h0, i_in_item.source_address[15:0]}
              + {4'h0, i_in_item.destination_address[31:16]}
              + {4'h0, i_in_item.destination_address[15:0]};
    end

    assign o_in_stall = r_valid && i_q_full;
    assign load       = !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_entry <= n_entry;
            r_sum   <= n_sum;
        end
    end

    // end-around carry, two folds clear any carry from a 20-bit sum
    always_comb begin
        fold1 = {1'b0, r_sum[15:0]} + {13'h0000, r_sum[19:16]};
        fold2 = fold1[15:0] + {15'h0000, fold1[16]};
        o_push_entry = r_entry;
        o_push_entry.words[2][15:0] = ~fold2;
    end

    assign o_push = r_valid && !i_q_full;

endmodule

// File: rtl/core/ipv4hb_queue.sv
// ----------------------------------------------------------------------------
// ipv4hb_queue
// two-entry queue of built headers between front and back end
// ----------------------------------------------------------------------------
module ipv4hb_queue
    import ipv4hb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_hdr_entry i_push_entry,
    output logic       o_full,
    input  logic       i_pop,
    output t_q_head    o_head
);

    t_hdr_entry  r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    logic [1:0]  n_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// File: rtl/core/ipv4hb_back.sv
// ----------------------------------------------------------------------------
// ipv4hb_back
// walks the queue head word by word into the output register
// ----------------------------------------------------------------------------
module ipv4hb_back
    import ipv4hb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_out_valid;
    t_out_item r_out_item;
    logic [2:0] r_pos;

    t_out_item n_out_item;
    logic      load;
    logic      last;

    assign load = !r_out_valid || !i_out_stall;
    assign last = i_head.entry.err || (r_pos == HDR_LAST_POS);
    assign o_pop = load && i_head.valid && last;

    always_comb begin
        if (i_head.entry.err) begin
            n_out_item.header_word  = 32'h0000_0000;
            n_out_item.word_index   = 3'd0;
            n_out_item.last_word    = 1'b1;
            n_out_item.length_error = 1'b1;
        end else begin
            n_out_item.header_word  = i_head.entry.words[r_pos];
            n_out_item.word_index   = r_pos;
            n_out_item.last_word    = (r_pos == HDR_LAST_POS);
            n_out_item.length_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= 3'd0;
        end else if (load) begin
            r_out_valid <= i_head.valid;
            if (i_head.valid) begin
                r_pos <= last ? 3'd0 : r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head.valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/core/ipv4_header_builder.sv
// ----------------------------------------------------------------------------
// ipv4_header_builder
// builds the 20-byte ipv4 header of a udp fragment as five 32-bit words
// ----------------------------------------------------------------------------
// usage
//   input channel: one transaction per datagram fragment (length, id,
//   offset, more-fragments flag, addresses), taken on i_in_valid && !o_in_stall
//   output channel: five transactions per input, header words 0..4 in network
//   order with last_word on word 4; if payload + 20 exceeds 65535 a single
//   transaction with length_error set and a zero word is given instead
//   path: a taken input is registered in the front, written into the queue,
//   then loaded into the output register
//   rate: the output register moves one header word per cycle while
//   i_out_stall is low; a length error gives one word instead of five
//   the front keeps accepting while the back emits, up to two built headers
//   wait in the queue plus one in the front register
//   reset: synchronous on i_rst_n low, clears all valid flags and the word
//   position, no transaction is in flight afterwards
//   receiver stall: i_out_stall holds the output register; the queue fills
//   and o_in_stall rises only once front and queue are both full
// ----------------------------------------------------------------------------
module ipv4_header_builder
    import ipv4hb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // front to queue
    logic       push;
    t_hdr_entry push_entry;
    logic       q_full;

    // queue to back
    t_q_head    q_head;
    logic       pop;

    // length check, header assembly and checksum
    ipv4hb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_push       (push),
        .o_push_entry (push_entry),
        .i_q_full     (q_full)
    );

    // decouples header building from word emission
    ipv4hb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head       (q_head)
    );

    // word sequencer and output register
    ipv4hb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for ipv4_header_builder: directed and random fragment
// descriptors go in, every header word coming out is compared against a
// header and checksum computed inside the bench
// ----------------------------------------------------------------------------
module tb_top
    import ipv4hb_pkg::*;
();

    // bench timing and stimulus sizes
    localparam int unsigned RESET_CYCLES    = 8;
    localparam int unsigned RANDOM_ITEMS    = 480;
    localparam int unsigned IDLE_PERCENT    = 18;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned HOLD_OFF_AT     = 120;
    localparam int unsigned PAUSE_AT        = 320;
    localparam int unsigned STEADY_FROM     = 200;
    localparam int unsigned STEADY_TO       = 280;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned STUCK_LIMIT     = 1000;

    // largest total length the header can carry
    localparam logic [16:0] MAX_TOTAL_LEN   = 17'd65535;

    // ------------------------------------------------------------------------
    // scoreboard: builds the expected header words for every accepted
    // fragment transaction and matches them against the output transactions
    // ------------------------------------------------------------------------
    class header_scoreboard;
        t_out_item   pending_words[$];
        int unsigned n_fragments;
        int unsigned n_overlength;
        int unsigned n_words;
        int unsigned n_failures;

        // one's-complement sum of the ten 16-bit halves, folded until no
        // carry is left, then inverted
        function logic [15:0] header_checksum(logic [31:0] w [HDR_WORDS]);
            logic [31:0] sum;
            sum = '0;
            for (int k = 0; k < HDR_WORDS; k++) begin
                sum += {16'h0, w[k][31:16]};
                sum += {16'h0, w[k][15:0]};
            end
            while (sum[31:16] != 16'h0) begin
                sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
            end
            return ~sum[15:0];
        endfunction

        // predict the output transactions of one accepted fragment
        function void note_fragment(t_in_item f);
            logic [16:0] total;
            logic [31:0] w [HDR_WORDS];
            t_out_item   r;
            total = {1'b0, f.payload_length} + HDR_BYTES;
            n_fragments++;
            if (total > MAX_TOTAL_LEN) begin
                // over-length: one zero word flagged as an error
                n_overlength++;
                r = '{header_word: '0, word_index: '0, last_word: 1'b1,
                      length_error: 1'b1};
                pending_words.push_back(r);
                return;
            end
            w[0] = {VER_IHL, 8'h00, total[15:0]};
            w[1] = {f.datagram_id, 2'b00, f.more_frag, f.frag_offset};
            w[2] = {TTL_VALUE, PROTO_UDP, 16'h0000};
            w[3] = f.source_address;
            w[4] = f.destination_address;
            w[2][15:0] = header_checksum(w);
            for (int k = 0; k < HDR_WORDS; k++) begin
                r.header_word  = w[k];
                r.word_index   = 3'(k);
                r.last_word    = (3'(k) == HDR_LAST_POS);
                r.length_error = 1'b0;
                pending_words.push_back(r);
            end
        endfunction

        // compare one output transaction with the oldest prediction
        function void check_word(t_out_item got);
            t_out_item want;
            n_words++;
            if (pending_words.size() == 0) begin
                $error("unexpected header word %h (index %0d), nothing pending",
                       got.header_word, got.word_index);
                n_failures++;
                return;
            end
            want = pending_words.pop_front();
            if (got.header_word !== want.header_word) begin
                $error("header_word: expected %h, got %h",
                       want.header_word, got.header_word);
                n_failures++;
            end
            if (got.word_index !== want.word_index) begin
                $error("word_index: expected %0d, got %0d",
                       want.word_index, got.word_index);
                n_failures++;
            end
            if (got.last_word !== want.last_word) begin
                $error("last_word: expected %0b, got %0b",
                       want.last_word, got.last_word);
                n_failures++;
            end
            if (got.length_error !== want.length_error) begin
                $error("length_error: expected %0b, got %0b",
                       want.length_error, got.length_error);
                n_failures++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_words.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    always #5 i_clk = ~i_clk;

    ipv4_header_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    header_scoreboard sb = new();

    // fragments accepted so far, written only by the sender
    int unsigned items_sent = 0;
    // no idling on either side while this window is open
    logic        steady_flow;
    logic        in_taken;
    logic        out_taken;
    int unsigned stuck_cycles = 0;

    assign steady_flow = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
    assign in_taken    = i_in_valid && !o_in_stall;
    assign out_taken   = o_out_valid && !i_out_stall;

    // ------------------------------------------------------------------------
    // monitor: both channels are sampled at the rising edge, before the
    // block's own registers move
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                sb.note_fragment(i_in_item);
            end
            if (out_taken) begin
                sb.check_word(o_out_item);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || in_taken || out_taken) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", STUCK_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall, one long hold-off once the sender reaches
    // HOLD_OFF_AT so the queue fills and the input side backs up
    // ------------------------------------------------------------------------
    initial begin
        bit hold_off_done;
        hold_off_done = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_off_done && items_sent >= HOLD_OFF_AT) begin
                hold_off_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // called at a falling edge, returns at the falling edge after the
    // transaction was taken, with valid still high
    task automatic send_fragment(t_in_item f);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= f;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_in_item fragment(logic [15:0] len, logic [15:0] id,
                                          logic [12:0] off, logic mf,
                                          logic [31:0] src, logic [31:0] dst);
        t_in_item f;
        f.payload_length      = len;
        f.datagram_id         = id;
        f.frag_offset         = off;
        f.more_frag           = mf;
        f.source_address      = src;
        f.destination_address = dst;
        return f;
    endfunction

    // mostly legal lengths, a fair share at the over-length boundary
    function automatic t_in_item random_fragment();
        t_in_item    f;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            f.payload_length = 16'($urandom_range(65535, 65516));
        end else if (pick < 16) begin
            f.payload_length = 16'($urandom_range(65515, 65490));
        end else if (pick < 60) begin
            f.payload_length = 16'($urandom_range(1500));
        end else begin
            f.payload_length = 16'($urandom_range(65515));
        end
        f.datagram_id         = 16'($urandom);
        f.frag_offset         = 13'($urandom);
        f.more_frag           = 1'($urandom);
        f.source_address      = $urandom;
        f.destination_address = $urandom;
        return f;
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // smallest header, all fields zero
        send_fragment(fragment(16'd0, 16'h0000, 13'h0000, 1'b0, 32'h0, 32'h0));
        // longest legal datagram with every field bit set
        send_fragment(fragment(16'd65515, 16'hffff, 13'h1fff, 1'b1,
                               32'hffff_ffff, 32'hffff_ffff));
        // one byte too long, then the largest length
        send_fragment(fragment(16'd65516, 16'h1234, 13'h0001, 1'b0,
                               32'h0a00_0001, 32'h0a00_0002));
        send_fragment(fragment(16'd65535, 16'hffff, 13'h1fff, 1'b1,
                               32'hffff_ffff, 32'hffff_ffff));
        // legal right after an error
        send_fragment(fragment(16'd1472, 16'hbeef, 13'd185, 1'b1,
                               32'hc0a8_010a, 32'h0a00_0001));
        // top offset bit alone, flag clear
        send_fragment(fragment(16'd8, 16'h0001, 13'h1000, 1'b0,
                               32'h7f00_0001, 32'h7f00_0001));
        // full offset, no flag, mixed addresses
        send_fragment(fragment(16'd100, 16'h8000, 13'h1fff, 1'b0,
                               32'hffff_ffff, 32'h0000_0000));
        send_fragment(fragment(16'd65514, 16'h7fff, 13'h0aaa, 1'b1,
                               32'h0000_0000, 32'hffff_ffff));
        // first fold leaves a carry that needs a second fold
        send_fragment(fragment(16'd0, 16'h0000, 13'h0000, 1'b0,
                               32'hffff_ffff, 32'h0000_7adb));
        // sum folds to all ones, checksum comes out zero
        send_fragment(fragment(16'd0, 16'h0000, 13'h0000, 1'b0,
                               32'h0000_0000, 32'h0000_7ada));
        // two over-length transactions back to back
        send_fragment(fragment(16'd65520, 16'h0000, 13'h0000, 1'b0, 32'h0, 32'h0));
        send_fragment(fragment(16'd65530, 16'h5555, 13'h1555, 1'b1,
                               32'h5555_5555, 32'haaaa_aaaa));
        send_fragment(fragment(16'd576, 16'haaaa, 13'h0555, 1'b0,
                               32'haaaa_aaaa, 32'h5555_5555));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_fragment(random_fragment());
            // let everything drain with the input idle
            if (items_sent == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                while (sb.outstanding() != 0) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("ran %0d fragment transactions (%0d over-length), checked %0d header words",
                 sb.n_fragments, sb.n_overlength, sb.n_words);
        $display("included a %0d-cycle receiver hold-off and a full drain with the input idle",
                 HOLD_OFF_CYCLES);
        if (sb.n_failures == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d words still pending",
                     sb.n_failures, sb.outstanding());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
